// ===== src/p1td_pkg.sv =====
// Shared types, character codes and result codes of the P1 telegram deframer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package p1td_pkg;

    // Characters that frame a telegram.
    localparam logic [7:0] CH_START = 8'h2F;   // '/'
    localparam logic [7:0] CH_FIVE  = 8'h35;   // '5'
    localparam logic [7:0] CH_BANG  = 8'h21;   // '!'
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Reflected CRC-16 polynomial.
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_HUNT   = 4'd0,
        PH_HEADER = 4'd1,
        PH_ID0    = 4'd2,
        PH_ID1    = 4'd3,
        PH_ID2    = 4'd4,
        PH_ID3    = 4'd5,
        PH_BODY   = 4'd6,
        PH_SUM    = 4'd7
    } phase_t;

    // Byte classes.
    localparam logic [1:0] CLS_OUTSIDE = 2'd0;
    localparam logic [1:0] CLS_HEADER  = 2'd1;
    localparam logic [1:0] CLS_BODY    = 2'd2;
    localparam logic [1:0] CLS_TERM    = 2'd3;

    // Telegram status codes.
    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_VALID    = 2'd1;
    localparam logic [1:0] ST_TRAILER  = 2'd2;
    localparam logic [1:0] ST_MISMATCH = 2'd3;

    // Count of checksum hex digits (also the position of the CR) and length of the checksum field.
    localparam logic [2:0] SUM_DIGITS  = 3'd4;
    localparam logic [2:0] SUM_LENGTH  = 3'd6;

    // One result item.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [1:0]  byte_class;
        logic        telegram_done;
        logic [1:0]  telegram_status;
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
    } result_t;

    // Hex digit decode: bit 4 set marks a character that is not a hex digit.
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [4:0] n;
        begin
            n = 5'h10;
            if (b >= 8'h30 && b <= 8'h39) begin
                n = {1'b0, b[3:0]};
            end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
                n = {1'b0, b[3:0] + 4'd9};
            end
            return n;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/p1_telegram_deframer_crc16.sv =====
// P1 telegram deframer with CRC-16 check: top level with input and result registers.
// An accepted request passes through the input register and then the result register
// before its result appears on the m_ ports. Depends on p1td_pkg and p1td_parse_core.
// Throughput: one byte per cycle while the sink keeps taking results, set by the
// combinational byte step of the parser and CRC update. Reset (aresetn, synchronous,
// active low) empties both registers and returns the parser to hunting for '/' with a zero CRC.
`timescale 1ns / 1ps
`default_nettype none

module p1_telegram_deframer_crc16 (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_data_byte,
    output logic [1:0]       m_byte_class,
    output logic             m_telegram_done,
    output logic [1:0]       m_telegram_status,
    output logic [15:0]      m_computed_crc,
    output logic [15:0]      m_received_crc
);
    import p1td_pkg::*;

    // Input register: holds one accepted request until the parser consumes it.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Result register: holds one finished result until the sink takes it.
    logic       out_valid_reg;
    result_t    out_reg;

    result_t    core_result;
    logic       advance;

    // The parser steps whenever the input register holds a byte and the result
    // register is free or is being emptied in this same cycle. Its state moves on
    // only then, so every byte is parsed exactly once.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);

    // A new request may enter whenever the input register is empty or its byte is
    // moving on now; this keeps one byte per cycle flowing even with a full result
    // register, as long as the sink keeps taking results.
    assign s_ready = !in_valid_reg || advance;

    p1td_parse_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .rx_byte (in_byte_reg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_data_byte       = out_reg.data_byte;
    assign m_byte_class      = out_reg.byte_class;
    assign m_telegram_done   = out_reg.telegram_done;
    assign m_telegram_status = out_reg.telegram_status;
    assign m_computed_crc    = out_reg.computed_crc;
    assign m_received_crc    = out_reg.received_crc;

    // A status is reported only together with the end of a telegram.
    a_status_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_telegram_done |-> m_telegram_status == ST_NONE)
        else $error("telegram status reported without telegram end");

    // The byte that ends a telegram is always a checksum or trailer byte with a status.
    a_done_is_term: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_telegram_done |->
            m_byte_class == CLS_TERM && m_telegram_status != ST_NONE)
        else $error("telegram end on a byte that is not a trailer byte");

    // A byte held in the input register is not dropped while the result side stalls.
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("stalled input byte lost");

    // A stalled result stays in place.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(out_reg))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== src/p1td_crc_byte.sv =====
// One-byte update of the reflected CRC-16, unrolled over the eight bits.
// Depends on p1td_pkg for the polynomial.
`timescale 1ns / 1ps
`default_nettype none

module p1td_crc_byte (
    input  wire logic [15:0] crc_in,
    input  wire logic [7:0]  data_in,
    output logic [15:0]      crc_out
);
    import p1td_pkg::*;

    logic [15:0] r;

    always_comb begin
        r = crc_in ^ {8'h00, data_in};
        for (int i = 0; i < 8; i++) begin
            if (r[0]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        crc_out = r;
    end

endmodule

`default_nettype wire

// ===== src/p1td_parse_core.sv =====
// Telegram parser: phase and checksum state registers plus the per-byte
// next-state logic. Depends on p1td_pkg and p1td_crc_byte.
`timescale 1ns / 1ps
`default_nettype none

module p1td_parse_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step_en,
    input  wire logic [7:0]    rx_byte,
    output p1td_pkg::result_t  result
);
    import p1td_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [2:0]  sum_cnt_reg, sum_cnt_next;
    logic [15:0] sum_val_reg, sum_val_next;
    logic        hex_ok_reg, hex_ok_next;
    logic        trl_ok_reg, trl_ok_next;

    logic [15:0] crc_seed;
    logic [15:0] crc_upd;
    logic [2:0]  hdr_inc;
    logic [2:0]  sum_inc;
    logic [4:0]  nib;

    // A start character seen while hunting restarts the CRC from zero.
    assign crc_seed = (phase_reg == PH_HUNT && rx_byte == CH_START) ? 16'h0000 : crc_reg;

    p1td_crc_byte u_crc (
        .crc_in  (crc_seed),
        .data_in (rx_byte),
        .crc_out (crc_upd)
    );

    always_comb begin
        phase_next   = phase_reg;
        crc_next     = crc_reg;
        hdr_cnt_next = hdr_cnt_reg;
        sum_cnt_next = sum_cnt_reg;
        sum_val_next = sum_val_reg;
        hex_ok_next  = hex_ok_reg;
        trl_ok_next  = trl_ok_reg;
        hdr_inc      = (hdr_cnt_reg < 3'd7) ? hdr_cnt_reg + 3'd1 : hdr_cnt_reg;
        sum_inc      = sum_cnt_reg + 3'd1;
        nib          = hex_nibble(rx_byte);
        result       = '0;
        result.data_byte = rx_byte;

        if (phase_reg != PH_SUM) begin
            crc_next = crc_upd;
        end

        case (phase_reg)
            PH_HUNT: begin
                if (rx_byte == CH_START) begin
                    hdr_cnt_next      = 3'd1;
                    phase_next        = PH_HEADER;
                    result.byte_class = CLS_HEADER;
                end
            end
            PH_HEADER: begin
                result.byte_class = CLS_HEADER;
                hdr_cnt_next      = hdr_inc;
                if (hdr_inc >= 3'd4 && rx_byte == CH_FIVE) begin
                    phase_next = PH_ID0;
                end
            end
            PH_ID0: begin
                result.byte_class = CLS_HEADER;
                if (rx_byte == CH_CR) begin
                    phase_next = PH_ID1;
                end
            end
            PH_ID1: begin
                result.byte_class = CLS_HEADER;
                phase_next = (rx_byte == CH_LF) ? PH_ID2 : PH_HUNT;
            end
            PH_ID2: begin
                result.byte_class = CLS_HEADER;
                phase_next = (rx_byte == CH_CR) ? PH_ID3 : PH_HUNT;
            end
            PH_ID3: begin
                result.byte_class = CLS_HEADER;
                phase_next = (rx_byte == CH_LF) ? PH_BODY : PH_HUNT;
            end
            PH_BODY: begin
                if (rx_byte == CH_BANG) begin
                    result.byte_class = CLS_TERM;
                    phase_next        = PH_SUM;
                    sum_cnt_next      = 3'd0;
                    sum_val_next      = 16'h0000;
                    hex_ok_next       = 1'b1;
                    trl_ok_next       = 1'b1;
                end else begin
                    result.byte_class = CLS_BODY;
                end
            end
            PH_SUM: begin
                result.byte_class = CLS_TERM;
                if (sum_cnt_reg < SUM_DIGITS) begin
                    // A bad digit shifts in zero and spoils the comparison.
                    if (nib[4]) begin
                        hex_ok_next = 1'b0;
                    end
                    sum_val_next = {sum_val_reg[11:0], nib[4] ? 4'h0 : nib[3:0]};
                end else if (sum_cnt_reg == SUM_DIGITS) begin
                    if (rx_byte != CH_CR) begin
                        trl_ok_next = 1'b0;
                    end
                end else begin
                    if (rx_byte != CH_LF) begin
                        trl_ok_next = 1'b0;
                    end
                end
                sum_cnt_next = sum_inc;
                if (sum_inc >= SUM_LENGTH) begin
                    result.telegram_done = 1'b1;
                    if (!trl_ok_next) begin
                        result.telegram_status = ST_TRAILER;
                    end else if (!hex_ok_next || sum_val_next != crc_reg) begin
                        result.telegram_status = ST_MISMATCH;
                    end else begin
                        result.telegram_status = ST_VALID;
                    end
                end
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase

        result.computed_crc = crc_next;
        result.received_crc = sum_val_next;

        if (result.telegram_done) begin
            phase_next   = PH_HUNT;
            crc_next     = 16'h0000;
            sum_cnt_next = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            crc_reg     <= 16'h0000;
            hdr_cnt_reg <= 3'd0;
            sum_cnt_reg <= 3'd0;
            sum_val_reg <= 16'h0000;
            hex_ok_reg  <= 1'b1;
            trl_ok_reg  <= 1'b1;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            crc_reg     <= crc_next;
            hdr_cnt_reg <= hdr_cnt_next;
            sum_cnt_reg <= sum_cnt_next;
            sum_val_reg <= sum_val_next;
            hex_ok_reg  <= hex_ok_next;
            trl_ok_reg  <= trl_ok_next;
        end
    end

endmodule

`default_nettype wire
